@@ hw/rtl/tpt_pkg.sv @@
`default_nettype none

package tpt_pkg;

   localparam int OFFSET_BITS = 12;
   localparam int TABLE_BITS = 10;
   localparam int FRAME_BITS = 20;
   localparam int PHYS_BITS = 32;

   localparam logic [FRAME_BITS-1:0] FRAME_ONES = '1;
   localparam logic [PHYS_BITS-1:0] NO_MAPPING = '1;

   typedef enum logic [1:0] {
      CMD_MAP       = 2'd0,
      CMD_UNMAP     = 2'd1,
      CMD_TRANSLATE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_UNALIGNED  = 2'd1,
      STATUS_MAPPED     = 2'd2,
      STATUS_NOT_MAPPED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   typedef struct packed {
      logic present;
      logic writable;
      logic user;
      logic [FRAME_BITS-1:0] frame;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{present: 1'b0, writable: 1'b0, user: 1'b0,
                                         frame: FRAME_ONES};

   typedef struct packed {
      logic page_we;
      logic dir_we;
      logic dir_val;
      entry_type entry;
   } store_ctl_type;

   typedef struct packed {
      status_type status;
      logic [PHYS_BITS-1:0] paddr;
      logic [FRAME_BITS-1:0] freed_frame;
      logic table_present;
      entry_type entry;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/tpt_req_if.sv @@
`default_nettype none

interface tpt_req_if #(
   parameter int VADDR_BITS = 26
) ();
   logic valid;
   logic ready;
   logic [1:0] cmd;
   logic [VADDR_BITS-1:0] virt_addr;
   logic [tpt_pkg::FRAME_BITS-1:0] frame_number;
   logic kernel_only;
   logic writable;

   modport source (
      output valid, cmd, virt_addr, frame_number, kernel_only, writable,
      input ready
   );
   modport sink (
      input valid, cmd, virt_addr, frame_number, kernel_only, writable,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/tpt_rsp_if.sv @@
`default_nettype none

interface tpt_rsp_if ();
   logic valid;
   logic ready;
   tpt_pkg::status_type status;
   logic [tpt_pkg::PHYS_BITS-1:0] paddr;
   logic [tpt_pkg::FRAME_BITS-1:0] freed_frame;
   logic table_present;
   logic entry_present;
   logic entry_writable;
   logic entry_user;
   logic [tpt_pkg::FRAME_BITS-1:0] entry_frame;

   modport source (
      output valid, status, paddr, freed_frame, table_present, entry_present,
         entry_writable, entry_user, entry_frame,
      input ready
   );
   modport sink (
      input valid, status, paddr, freed_frame, table_present, entry_present,
         entry_writable, entry_user, entry_frame,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/two_level_page_table.sv @@
// flow: a request is registered and its page entry and directory bit are read; the
// response is registered in EXEC once the held one is taken; no new request is taken
// until then, due to the read-modify-write of the page entry and directory bit memories
// (one read, then one write); reset: synchronous, active high; a clearing pass then
// writes every page entry and directory bit, with req ready held low
`default_nettype none

module two_level_page_table #(
   parameter int VADDR_BITS = 26
) (
   input  wire logic clock,
   input  wire logic reset,
   tpt_req_if.sink   req_ch,
   tpt_rsp_if.source rsp_ch
);

   localparam int PAGE_AW = VADDR_BITS - tpt_pkg::OFFSET_BITS;
   localparam int TBL_BITS = PAGE_AW - tpt_pkg::TABLE_BITS;
   localparam int TBL_AW = (TBL_BITS > 0) ? TBL_BITS : 1;

   tpt_pkg::fsm_type state_ff, state_in;
   logic [PAGE_AW-1:0] clr_ff, clr_in;

   logic [1:0] cmd_ff;
   logic [VADDR_BITS-1:0] va_ff;
   logic [tpt_pkg::FRAME_BITS-1:0] frame_ff;
   logic kern_ff;
   logic wr_ff;

   logic rsp_valid_ff, rsp_valid_in;
   tpt_pkg::rsp_type rsp_data_ff;

   logic req_ready;
   logic accept;
   logic commit;
   logic clear_done;

   tpt_pkg::store_ctl_type store_ctl;
   tpt_pkg::store_ctl_type exec_ctl;
   tpt_pkg::rsp_type exec_rsp;
   tpt_pkg::entry_type entry_rd;
   logic table_rd;
   logic [PAGE_AW-1:0] wr_page_addr;
   logic [TBL_AW-1:0] wr_tbl_addr;
   logic [TBL_AW-1:0] rd_tbl_addr;

   assign accept = req_ch.valid && req_ready;
   assign clear_done = (clr_ff == '1);

   generate
      if (TBL_BITS > 0) begin : g_dir
         assign rd_tbl_addr = req_ch.virt_addr[VADDR_BITS-1:VADDR_BITS-TBL_AW];
         assign wr_tbl_addr = wr_page_addr[PAGE_AW-1:PAGE_AW-TBL_AW];
      end else begin : g_single
         assign rd_tbl_addr = '0;
         assign wr_tbl_addr = '0;
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      case (state_ff)
         tpt_pkg::FSM_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clear_done) begin
               state_in = tpt_pkg::FSM_IDLE;
            end
         end
         tpt_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = tpt_pkg::FSM_EXEC;
            end
         end
         tpt_pkg::FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = tpt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = tpt_pkg::FSM_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      commit = 1'b0;
      store_ctl = '0;
      wr_page_addr = va_ff[VADDR_BITS-1:tpt_pkg::OFFSET_BITS];
      case (state_ff)
         tpt_pkg::FSM_CLEAR: begin
            store_ctl.page_we = 1'b1;
            store_ctl.dir_we = 1'b1;
            store_ctl.dir_val = 1'b0;
            store_ctl.entry = tpt_pkg::EMPTY_ENTRY;
            wr_page_addr = clr_ff;
         end
         tpt_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
         end
         tpt_pkg::FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               commit = 1'b1;
               store_ctl = exec_ctl;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpt_pkg::FSM_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_ch.cmd;
         va_ff <= req_ch.virt_addr;
         frame_ff <= req_ch.frame_number;
         kern_ff <= req_ch.kernel_only;
         wr_ff <= req_ch.writable;
      end
      if (commit) begin
         rsp_data_ff <= exec_rsp;
      end
   end

   tpt_store #(
      .PAGE_AW(PAGE_AW),
      .TBL_AW(TBL_AW)
   ) u_store (
      .clock(clock),
      .rd_en(accept),
      .page_rd_addr(req_ch.virt_addr[VADDR_BITS-1:tpt_pkg::OFFSET_BITS]),
      .dir_rd_addr(rd_tbl_addr),
      .page_rd_data(entry_rd),
      .dir_rd_data(table_rd),
      .ctl(store_ctl),
      .page_wr_addr(wr_page_addr),
      .dir_wr_addr(wr_tbl_addr)
   );

   tpt_exec #(
      .VADDR_BITS(VADDR_BITS)
   ) u_exec (
      .cmd(cmd_ff),
      .virt_addr(va_ff),
      .frame_number(frame_ff),
      .kernel_only(kern_ff),
      .writable(wr_ff),
      .entry_rd(entry_rd),
      .table_rd(table_rd),
      .ctl(exec_ctl),
      .rsp(exec_rsp)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_data_ff.status;
   assign rsp_ch.paddr = rsp_data_ff.paddr;
   assign rsp_ch.freed_frame = rsp_data_ff.freed_frame;
   assign rsp_ch.table_present = rsp_data_ff.table_present;
   assign rsp_ch.entry_present = rsp_data_ff.entry.present;
   assign rsp_ch.entry_writable = rsp_data_ff.entry.writable;
   assign rsp_ch.entry_user = rsp_data_ff.entry.user;
   assign rsp_ch.entry_frame = rsp_data_ff.entry.frame;

endmodule

`default_nettype wire

@@ hw/rtl/tpt_store.sv @@
`default_nettype none

module tpt_store #(
   parameter int PAGE_AW = 14,
   parameter int TBL_AW = 4
) (
   input  wire logic                   clock,
   input  wire logic                   rd_en,
   input  wire logic [PAGE_AW-1:0]     page_rd_addr,
   input  wire logic [TBL_AW-1:0]      dir_rd_addr,
   output tpt_pkg::entry_type          page_rd_data,
   output logic                        dir_rd_data,
   input  wire tpt_pkg::store_ctl_type ctl,
   input  wire logic [PAGE_AW-1:0]     page_wr_addr,
   input  wire logic [TBL_AW-1:0]      dir_wr_addr
);

   tpt_pkg::entry_type page_mem [2**PAGE_AW];
   logic dir_mem [2**TBL_AW];

   tpt_pkg::entry_type page_rd_ff;
   logic dir_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.page_we) begin
         page_mem[page_wr_addr] <= ctl.entry;
      end
      if (rd_en) begin
         page_rd_ff <= page_mem[page_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.dir_we) begin
         dir_mem[dir_wr_addr] <= ctl.dir_val;
      end
      if (rd_en) begin
         dir_rd_ff <= dir_mem[dir_rd_addr];
      end
   end

   assign page_rd_data = page_rd_ff;
   assign dir_rd_data = dir_rd_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tpt_exec.sv @@
`default_nettype none

module tpt_exec #(
   parameter int VADDR_BITS = 26
) (
   input  wire logic [1:0]                       cmd,
   input  wire logic [VADDR_BITS-1:0]            virt_addr,
   input  wire logic [tpt_pkg::FRAME_BITS-1:0]   frame_number,
   input  wire logic                             kernel_only,
   input  wire logic                             writable,
   input  wire tpt_pkg::entry_type               entry_rd,
   input  wire logic                             table_rd,
   output tpt_pkg::store_ctl_type                ctl,
   output tpt_pkg::rsp_type                      rsp
);

   always_comb begin
      logic aligned;
      logic tbl_after;
      tpt_pkg::entry_type e_new;
      tpt_pkg::status_type status;
      logic [tpt_pkg::FRAME_BITS-1:0] freed;

      aligned = (virt_addr[tpt_pkg::OFFSET_BITS-1:0] == '0);
      status = tpt_pkg::STATUS_OK;
      freed = '0;
      e_new = entry_rd;
      ctl.page_we = 1'b0;
      ctl.dir_we = 1'b0;
      case (cmd)
         tpt_pkg::CMD_MAP: begin
            if (!aligned) begin
               status = tpt_pkg::STATUS_UNALIGNED;
            end else if (table_rd && entry_rd.present) begin
               status = tpt_pkg::STATUS_MAPPED;
            end else begin
               e_new.present = 1'b1;
               e_new.writable = writable;
               e_new.user = !kernel_only;
               e_new.frame = frame_number;
               ctl.page_we = 1'b1;
               ctl.dir_we = 1'b1;
            end
         end
         tpt_pkg::CMD_UNMAP: begin
            if (!aligned) begin
               status = tpt_pkg::STATUS_UNALIGNED;
            end else if (!table_rd || !entry_rd.present) begin
               status = tpt_pkg::STATUS_NOT_MAPPED;
            end else begin
               freed = entry_rd.frame;
               e_new.present = 1'b0;
               e_new.frame = tpt_pkg::FRAME_ONES;
               ctl.page_we = 1'b1;
            end
         end
         default: begin
         end
      endcase
      tbl_after = table_rd | ctl.dir_we;
      ctl.dir_val = 1'b1;
      ctl.entry = e_new;

      rsp.status = status;
      rsp.freed_frame = freed;
      rsp.table_present = tbl_after;
      rsp.entry = e_new;
      if (tbl_after && e_new.present) begin
         rsp.paddr = {e_new.frame, virt_addr[tpt_pkg::OFFSET_BITS-1:0]};
      end else begin
         rsp.paddr = tpt_pkg::NO_MAPPING;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/tpt_checker.sv @@
`default_nettype none

module tpt_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [1:0]                          rsp_status,
   input wire logic [tpt_pkg::PHYS_BITS-1:0]       rsp_paddr,
   input wire logic [tpt_pkg::FRAME_BITS-1:0]      rsp_freed_frame,
   input wire logic                                rsp_table_present,
   input wire logic                                rsp_entry_present,
   input wire logic [tpt_pkg::FRAME_BITS-1:0]      rsp_entry_frame
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_paddr)
         && $stable(rsp_status))
      else $error("response beat dropped or changed while stalled");

   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_freed_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != tpt_pkg::STATUS_OK) |-> rsp_freed_frame == '0)
      else $error("frame freed by a failed command");

   a_absent_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_table_present |-> !rsp_entry_present
         && (rsp_entry_frame == tpt_pkg::FRAME_ONES)
         && (rsp_paddr == tpt_pkg::NO_MAPPING))
      else $error("entry of an absent table is not empty");

endmodule

bind two_level_page_table tpt_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_status(rsp_ch.status),
   .rsp_paddr(rsp_ch.paddr),
   .rsp_freed_frame(rsp_ch.freed_frame),
   .rsp_table_present(rsp_ch.table_present),
   .rsp_entry_present(rsp_ch.entry_present),
   .rsp_entry_frame(rsp_ch.entry_frame)
);

`default_nettype wire

@@ tb/sv/two_level_page_table_tb.sv @@
`default_nettype none

module two_level_page_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VADDR_BITS = 26;
   localparam int PAGE_BITS = VADDR_BITS - tpt_pkg::OFFSET_BITS;
   localparam int DIR_BITS = PAGE_BITS - tpt_pkg::TABLE_BITS;
   localparam int PAGE_COUNT = 1 << PAGE_BITS;
   localparam int DIR_COUNT = 1 << DIR_BITS;
   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam int STALL_LIMIT = 100000;

   logic clock;
   logic reset;

   tpt_req_if #(.VADDR_BITS(VADDR_BITS)) req_ch ();
   tpt_rsp_if rsp_ch ();

   two_level_page_table #(.VADDR_BITS(VADDR_BITS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic dir_present [DIR_COUNT];
   tpt_pkg::entry_type page_store [PAGE_COUNT];
   tpt_pkg::rsp_type expected_rsp_q [$];
   logic [PAGE_BITS-1:0] hot_pages [$];

   int req_idle_pct;
   int rsp_idle_pct;
   int error_count;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // shadow copy of the directory and page entries, and the predicted response
   function automatic tpt_pkg::rsp_type predict_page_op(
         input logic [1:0] cmd,
         input logic [VADDR_BITS-1:0] va,
         input logic [tpt_pkg::FRAME_BITS-1:0] frame,
         input logic kern, input logic wr);
      logic [PAGE_BITS-1:0] page;
      logic [DIR_BITS-1:0] slot;
      logic aligned;
      tpt_pkg::entry_type e;
      tpt_pkg::rsp_type r;
      page = va[VADDR_BITS-1:tpt_pkg::OFFSET_BITS];
      slot = va[VADDR_BITS-1:tpt_pkg::OFFSET_BITS+tpt_pkg::TABLE_BITS];
      aligned = (va[tpt_pkg::OFFSET_BITS-1:0] == '0);
      e = page_store[page];
      r.status = tpt_pkg::STATUS_OK;
      r.freed_frame = '0;
      if (cmd == tpt_pkg::CMD_MAP) begin
         if (!aligned) begin
            r.status = tpt_pkg::STATUS_UNALIGNED;
         end else if (dir_present[slot] && e.present) begin
            r.status = tpt_pkg::STATUS_MAPPED;
         end else begin
            dir_present[slot] = 1'b1;
            e.present = 1'b1;
            e.writable = wr;
            e.user = ~kern;
            e.frame = frame;
            page_store[page] = e;
         end
      end else if (cmd == tpt_pkg::CMD_UNMAP) begin
         if (!aligned) begin
            r.status = tpt_pkg::STATUS_UNALIGNED;
         end else if (!dir_present[slot] || !e.present) begin
            r.status = tpt_pkg::STATUS_NOT_MAPPED;
         end else begin
            r.freed_frame = e.frame;
            e.present = 1'b0;
            e.frame = tpt_pkg::FRAME_ONES;
            page_store[page] = e;
         end
      end
      if (dir_present[slot] && e.present)
         r.paddr = {e.frame, va[tpt_pkg::OFFSET_BITS-1:0]};
      else
         r.paddr = tpt_pkg::NO_MAPPING;
      r.table_present = dir_present[slot];
      r.entry = e;
      return r;
   endfunction

   task automatic send_req(input logic [1:0] cmd, input logic [VADDR_BITS-1:0] va,
                           input logic [tpt_pkg::FRAME_BITS-1:0] frame, input logic kern,
                           input logic wr);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.virt_addr <= va;
      req_ch.frame_number <= frame;
      req_ch.kernel_only <= kern;
      req_ch.writable <= wr;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_rsp_q.push_back(predict_page_op(cmd, va, frame, kern, wr));
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_val,
                  act_val);
         error_count++;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      tpt_pkg::rsp_type exp_rsp;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected response beat, expected none actual status %h",
                     $realtime, rsp_ch.status);
            error_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            check_field("status", 32'(exp_rsp.status), 32'(rsp_ch.status));
            check_field("paddr", exp_rsp.paddr, rsp_ch.paddr);
            check_field("freed_frame", 32'(exp_rsp.freed_frame), 32'(rsp_ch.freed_frame));
            check_field("table_present", 32'(exp_rsp.table_present),
                        32'(rsp_ch.table_present));
            check_field("entry_present", 32'(exp_rsp.entry.present),
                        32'(rsp_ch.entry_present));
            check_field("entry_writable", 32'(exp_rsp.entry.writable),
                        32'(rsp_ch.entry_writable));
            check_field("entry_user", 32'(exp_rsp.entry.user), 32'(rsp_ch.entry_user));
            check_field("entry_frame", 32'(exp_rsp.entry.frame), 32'(rsp_ch.entry_frame));
         end
      end
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      stall_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired", $realtime);
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic test_basic_mapping();
      send_req(tpt_pkg::CMD_TRANSLATE, 26'h0000000, 20'h00000, 1'b0, 1'b0);
      send_req(tpt_pkg::CMD_MAP, 26'h0000000, 20'h00000, 1'b0, 1'b1);
      send_req(tpt_pkg::CMD_TRANSLATE, 26'h0000FFF, 20'hFFFFF, 1'b1, 1'b1);
      send_req(tpt_pkg::CMD_MAP, 26'h0001000, tpt_pkg::FRAME_ONES, 1'b1, 1'b0);
      send_req(tpt_pkg::CMD_TRANSLATE, 26'h0001FFF, 20'h00000, 1'b0, 1'b0);
      send_req(tpt_pkg::CMD_UNMAP, 26'h0001000, 20'h00000, 1'b0, 1'b0);
      send_req(tpt_pkg::CMD_TRANSLATE, 26'h0001000, 20'h00000, 1'b0, 1'b0);
      send_req(tpt_pkg::CMD_MAP, 26'h3FFF000, 20'hA5A5A, 1'b0, 1'b1);
      send_req(tpt_pkg::CMD_TRANSLATE, 26'h3FFFFFF, 20'h5A5A5, 1'b1, 1'b0);
      send_req(tpt_pkg::CMD_UNMAP, 26'h3FFF000, 20'hFFFFF, 1'b1, 1'b1);
      send_req(tpt_pkg::CMD_MAP, 26'h3FFF000, 20'h00001, 1'b1, 1'b1);
      send_req(tpt_pkg::CMD_MAP, 26'h2ABC000, 20'h80000, 1'b0, 1'b0);
      send_req(tpt_pkg::CMD_TRANSLATE, 26'h2ABC555, 20'h00000, 1'b0, 1'b0);
   endtask

   task automatic test_error_status();
      send_req(tpt_pkg::CMD_UNMAP, 26'h1000000, 20'h12345, 1'b0, 1'b1);
      send_req(tpt_pkg::CMD_MAP, 26'h0000000, 20'h54321, 1'b1, 1'b0);
      send_req(tpt_pkg::CMD_UNMAP, 26'h0001000, 20'h00000, 1'b0, 1'b0);
      send_req(tpt_pkg::CMD_MAP, 26'h0002800, 20'hFFFFF, 1'b0, 1'b1);
      send_req(tpt_pkg::CMD_UNMAP, 26'h0000001, 20'h00000, 1'b0, 1'b0);
      send_req(tpt_pkg::CMD_MAP, 26'h3FFFFFF, 20'hFFFFF, 1'b1, 1'b1);
      send_req(tpt_pkg::CMD_TRANSLATE, 26'h1C00123, 20'h00000, 1'b0, 1'b0);
      send_req(CMD_RESERVED, 26'h3FFFFFF, 20'hFFFFF, 1'b1, 1'b1);
      send_req(CMD_RESERVED, 26'h0123456, 20'h00000, 1'b0, 1'b0);
      send_req(tpt_pkg::CMD_UNMAP, 26'h0000000, 20'h00000, 1'b0, 1'b0);
      send_req(tpt_pkg::CMD_UNMAP, 26'h0000000, 20'h00000, 1'b0, 1'b0);
   endtask

   task automatic test_random_traffic(input int n_items);
      logic [1:0] cmd;
      logic [PAGE_BITS-1:0] page;
      logic [tpt_pkg::OFFSET_BITS-1:0] offset;
      logic [VADDR_BITS-1:0] va;
      int pick;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            // mostly well-formed traffic on a small set of pages
            page = hot_pages[$urandom_range(0, hot_pages.size() - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 35)
               cmd = tpt_pkg::CMD_MAP;
            else if (pick < 60)
               cmd = tpt_pkg::CMD_UNMAP;
            else if (pick < 95)
               cmd = tpt_pkg::CMD_TRANSLATE;
            else
               cmd = CMD_RESERVED;
            offset = tpt_pkg::OFFSET_BITS'($urandom());
            if ((cmd == tpt_pkg::CMD_MAP || cmd == tpt_pkg::CMD_UNMAP) &&
                $urandom_range(0, 9) != 0)
               offset = '0;
            va = {page, offset};
         end else begin
            cmd = 2'($urandom_range(0, 3));
            va = VADDR_BITS'($urandom());
            if ($urandom_range(0, 1) == 0)
               va[tpt_pkg::OFFSET_BITS-1:0] = '0;
         end
         send_req(cmd, va, tpt_pkg::FRAME_BITS'($urandom()), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      logic [PAGE_BITS-1:0] base;
      error_count = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= tpt_pkg::CMD_TRANSLATE;
      req_ch.virt_addr <= '0;
      req_ch.frame_number <= '0;
      req_ch.kernel_only <= 1'b0;
      req_ch.writable <= 1'b0;
      for (int i = 0; i < DIR_COUNT; i++)
         dir_present[i] = 1'b0;
      for (int i = 0; i < PAGE_COUNT; i++)
         page_store[i] = tpt_pkg::EMPTY_ENTRY;
      for (int i = 0; i < 16; i++) begin
         base = PAGE_BITS'($urandom());
         hot_pages.push_back(base);
         hot_pages.push_back(base + 1'b1);
         hot_pages.push_back(base ^ {1'b1, {(PAGE_BITS-1){1'b0}}});
      end
      req_idle_pct = 15;
      rsp_idle_pct = 51;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_basic_mapping();
      test_error_status();
      test_random_traffic(380);
      req_idle_pct = 51;
      rsp_idle_pct = 15;
      test_random_traffic(385);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(385);

      req_ch.valid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
